// File: hdl/text_stream_line_formatter_assert.svh
`ifndef TEXT_STREAM_LINE_FORMATTER_ASSERT_SVH
`define TEXT_STREAM_LINE_FORMATTER_ASSERT_SVH

// checked at every edge outside reset
`define TSLF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TSLF_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/tslf_pkg.sv
`timescale 1ns / 1ps
package tslf_pkg;

	localparam logic [2:0] REG_NUMBER_MODE  = 3'd0;
	localparam logic [2:0] REG_SQUEEZE_EN   = 3'd1;
	localparam logic [2:0] REG_MARK_EOL     = 3'd2;
	localparam logic [2:0] REG_MARK_TAB     = 3'd3;
	localparam logic [2:0] REG_CTRL_VISIBLE = 3'd4;

	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;

	localparam logic [7:0] CTRL_LIMIT    = 8'd32;
	localparam logic [7:0] CARET_OFFSET  = 8'd64;
	localparam logic [7:0] HIGH_BASE     = 8'd128;
	localparam logic [7:0] HIGH_CTRL_TOP = 8'd159;
	localparam logic [7:0] META_BASE     = 8'd160;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;
	localparam int CMDQ_CNT_W = 3;

	typedef struct packed {
		logic [1:0] number_mode;
		logic       squeeze_en;
		logic       mark_eol;
		logic       mark_tab;
		logic       ctrl_visible;
	} cfg_t;

	typedef struct packed {
		logic            number;
		logic [3:0][7:0] exp_bytes;
		logic [1:0]      exp_last;
	} cmd_ctl_t;

endpackage

// File: hdl/tslf_front.sv
`timescale 1ns / 1ps
module tslf_front import tslf_pkg::*; #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	input  logic [7:0]                    text_byte,
	input  logic                          first_of_file,
	output logic                          cmd_push,
	output cmd_ctl_t                      cmd_ctl,
	output logic [NUMBER_DIGITS-1:0][7:0] cmd_digits
);

	localparam int CNT_W = NUMBER_DIGITS * 4;

	logic             at_line_start_q;
	logic [1:0]       blank_run_q;
	logic [CNT_W-1:0] line_count_q;

	logic             als;
	logic [1:0]       br;
	logic [CNT_W-1:0] cnt;
	logic             blank;
	logic             drop;
	logic             number;
	logic [1:0]       br_next;
	logic [CNT_W-1:0] cnt_inc;

	always_comb begin
		als = first_of_file ? 1'b1 : at_line_start_q;
		br  = first_of_file ? 2'd0 : blank_run_q;
		cnt = first_of_file ? CNT_W'(1) : line_count_q;
		blank = (text_byte == CH_NL);
		drop = 1'b0;
		br_next = br;
		if (als) begin
			if (cfg.squeeze_en && blank) begin
				br_next = (br < 2'd2) ? br + 2'd1 : br;
				drop = (br_next > 2'd1);
			end else begin
				br_next = blank ? 2'd1 : 2'd0;
			end
		end
		number = als && !drop && ((cfg.number_mode == NUM_ALL) ||
			(cfg.number_mode == NUM_NONBLANK && !blank));
	end

	// saturating BCD increment
	always_comb begin
		logic carry;
		logic all_nines;
		logic [3:0] d;
		carry = 1'b1;
		all_nines = 1'b1;
		cnt_inc = cnt;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (cnt[4*i +: 4] != 4'd9)
				all_nines = 1'b0;
		end
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = cnt[4*i +: 4];
			if (carry) begin
				if (d >= 4'd9) begin
					cnt_inc[4*i +: 4] = 4'd0;
				end else begin
					cnt_inc[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		if (all_nines)
			cnt_inc = cnt;
	end

	// digit characters, most significant first, leading zeros as spaces
	always_comb begin
		logic seen;
		logic [3:0] d;
		seen = 1'b0;
		for (int p = NUMBER_DIGITS - 1; p >= 0; p--) begin
			d = cnt[4*p +: 4];
			if (d != 4'd0 || p == 0)
				seen = 1'b1;
			cmd_digits[NUMBER_DIGITS-1-p] = seen ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
		end
	end

	always_comb begin
		cmd_ctl.number = number;
		cmd_ctl.exp_bytes = '0;
		cmd_ctl.exp_last = 2'd0;
		priority if (cfg.mark_eol && text_byte == CH_NL) begin
			cmd_ctl.exp_bytes[0] = CH_DOLLAR;
			cmd_ctl.exp_bytes[1] = text_byte;
			cmd_ctl.exp_last = 2'd1;
		end else if (cfg.mark_tab && text_byte == CH_TAB) begin
			cmd_ctl.exp_bytes[0] = CH_CARET;
			cmd_ctl.exp_bytes[1] = CH_I;
			cmd_ctl.exp_last = 2'd1;
		end else if (cfg.ctrl_visible && text_byte < CTRL_LIMIT &&
				text_byte != CH_NL && text_byte != CH_TAB) begin
			cmd_ctl.exp_bytes[0] = CH_CARET;
			cmd_ctl.exp_bytes[1] = text_byte + CARET_OFFSET;
			cmd_ctl.exp_last = 2'd1;
		end else if (cfg.ctrl_visible && text_byte >= HIGH_BASE &&
				text_byte <= HIGH_CTRL_TOP) begin
			cmd_ctl.exp_bytes[0] = CH_M;
			cmd_ctl.exp_bytes[1] = CH_DASH;
			cmd_ctl.exp_bytes[2] = CH_CARET;
			cmd_ctl.exp_bytes[3] = text_byte - CARET_OFFSET;
			cmd_ctl.exp_last = 2'd3;
		end else if (cfg.ctrl_visible && text_byte >= META_BASE) begin
			cmd_ctl.exp_bytes[0] = CH_M;
			cmd_ctl.exp_bytes[1] = CH_DASH;
			cmd_ctl.exp_bytes[2] = text_byte - HIGH_BASE;
			cmd_ctl.exp_last = 2'd2;
		end else begin
			cmd_ctl.exp_bytes[0] = text_byte;
		end
	end

	assign cmd_push = in_valid && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			blank_run_q     <= 2'd0;
			line_count_q    <= CNT_W'(1);
		end else if (in_valid) begin
			blank_run_q <= als ? br_next : br;
			if (drop) begin
				at_line_start_q <= 1'b1;
				line_count_q    <= cnt;
			end else begin
				at_line_start_q <= blank;
				line_count_q    <= number ? cnt_inc : cnt;
			end
		end
	end

endmodule

// File: hdl/tslf_cmd_fifo.sv
`timescale 1ns / 1ps
module tslf_cmd_fifo import tslf_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	logic [WIDTH-1:0]      mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (count_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			if (do_wr && !do_rd)
				count_q <= count_q + CMDQ_CNT_W'(1);
			else if (do_rd && !do_wr)
				count_q <= count_q - CMDQ_CNT_W'(1);
		end
	end

endmodule

// File: hdl/tslf_back.sv
`timescale 1ns / 1ps
module tslf_back import tslf_pkg::*; #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  cmd_ctl_t                      head_ctl,
	input  logic [NUMBER_DIGITS-1:0][7:0] head_digits,
	output logic                          head_pop,
	output logic                          out_valid,
	output logic [7:0]                    out_byte,
	output logic                          out_last,
	input  logic                          out_take
);

	localparam int NUM_LEN = NUMBER_DIGITS + 1;
	localparam int SEQ_MAX = NUMBER_DIGITS + 4;
	localparam int IDX_W   = $clog2(SEQ_MAX + 1);
	localparam int DIG_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic             adv;
	logic             num_part;
	logic [IDX_W-1:0] exp_idx;
	logic [1:0]       e;
	logic [7:0]       next_byte;
	logic             next_last;

	assign adv = !out_valid_q || out_take;

	always_comb begin
		num_part = head_ctl.number && (idx_q < IDX_W'(NUM_LEN));
		exp_idx  = idx_q - (head_ctl.number ? IDX_W'(NUM_LEN) : IDX_W'(0));
		e        = exp_idx[1:0];
		next_last = !num_part && (e == head_ctl.exp_last);
		if (num_part) begin
			if (idx_q == IDX_W'(NUMBER_DIGITS))
				next_byte = CH_TAB;
			else
				next_byte = head_digits[idx_q[DIG_W-1:0]];
		end else begin
			next_byte = head_ctl.exp_bytes[e];
		end
	end

	assign head_pop = adv && head_valid && next_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid)
				idx_q <= next_last ? '0 : idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			out_byte_q <= next_byte;
			out_last_q <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// File: hdl/text_stream_line_formatter.sv
`timescale 1ns / 1ps
// Line formatter for a text byte stream (numbering, squeeze, $ ends, ^I tabs,
// caret and M- notation). Input side is a queue write port: text_byte and
// first_of_file are taken at an edge with push high and full low. Output side
// is a queue read port: out_byte/last_of_run hold the oldest result while
// empty is low, and pop takes it. last_of_run marks the final byte an input
// byte produced. Registers go in through cfg_valid/cfg_ready/cfg_index/cfg_data,
// which the user must write only while the block is idle; the block does not
// enforce this. cfg_ready is always high. The first result passes through the
// command queue and the output register before it reaches the output ports.
// The output yields one byte per cycle while pop keeps taking it, and an
// expanded byte yields up to NUMBER_DIGITS+5 output bytes. The single output
// byte generator sets this rate; a four-entry command queue sits between the
// classifier and the generator.
// A squeezed blank line takes a push but yields no output.
// Reset clears the queue, the output stage, the line state (line start, line
// number 1) and all registers to zero. A stalled receiver holds the current
// byte; the command queue fills and full rises until pop resumes.
module text_stream_line_formatter import tslf_pkg::*; #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       first_of_file,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [1:0] cfg_data
);

	localparam int CMD_W = $bits(cmd_ctl_t) + NUMBER_DIGITS * 8;

	cfg_t                          cfg_q;
	logic                          in_valid;
	logic                          cmd_push;
	cmd_ctl_t                      cmd_ctl;
	logic [NUMBER_DIGITS-1:0][7:0] cmd_digits;
	logic [CMD_W-1:0]              q_rd_data;
	logic                          q_empty;
	cmd_ctl_t                      head_ctl;
	logic [NUMBER_DIGITS-1:0][7:0] head_digits;
	logic                          head_pop;
	logic                          out_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUMBER_MODE:  cfg_q.number_mode  <= cfg_data;
				REG_SQUEEZE_EN:   cfg_q.squeeze_en   <= cfg_data[0];
				REG_MARK_EOL:     cfg_q.mark_eol     <= cfg_data[0];
				REG_MARK_TAB:     cfg_q.mark_tab     <= cfg_data[0];
				REG_CTRL_VISIBLE: cfg_q.ctrl_visible <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_valid = push && !full;

	tslf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.text_byte    (text_byte),
		.first_of_file(first_of_file),
		.cmd_push     (cmd_push),
		.cmd_ctl      (cmd_ctl),
		.cmd_digits   (cmd_digits)
	);

	tslf_cmd_fifo #(
		.WIDTH(CMD_W)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_data({cmd_ctl, cmd_digits}),
		.full   (full),
		.rd_en  (head_pop),
		.rd_data(q_rd_data),
		.empty  (q_empty)
	);

	assign {head_ctl, head_digits} = q_rd_data;

	tslf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_ctl   (head_ctl),
		.head_digits(head_digits),
		.head_pop   (head_pop),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (last_of_run),
		.out_take   (pop)
	);

	assign empty = !out_valid;

endmodule

// File: hdl/tslf_checker.sv
`timescale 1ns / 1ps
`include "text_stream_line_formatter_assert.svh"
module tslf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_of_run
);

	`TSLF_ASSERT(a_out_hold, !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_run), "result changed while stalled")
	`TSLF_ASSERT_RST(a_reset_empty, !arst_n |=> empty, "result shown right after reset")
	`TSLF_ASSERT(a_full_holds, full && !empty && !pop |=> full, "queue drained while output stalled")
	`TSLF_ASSERT(a_run_continues, !empty && pop && !last_of_run |=> !empty, "gap inside an expansion run")

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.last_of_run(last_of_run)
);

// File: tb/tslf_output_checker.sv
`timescale 1ns / 1ps
module tslf_output_checker import tslf_pkg::*; #(
	parameter int DIGITS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] text_byte,
	input  logic       first_of_file,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] out_byte,
	input  logic       last_of_run,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [1:0] cfg_data,
	output int         mismatches,
	output int         outstanding,
	output int         chars_checked,
	output int         bytes_taken
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	out_char_t           pending_chars[$];
	cfg_t                settings;
	logic                at_line_start;
	logic [1:0]          blank_run;
	logic [4*DIGITS-1:0] line_bcd;
	int                  err_count;
	int                  chk_count;
	int                  take_count;

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		chars_checked = 0;
		bytes_taken   = 0;
		err_count     = 0;
		chk_count     = 0;
		take_count    = 0;
	end

	function automatic logic [4*DIGITS-1:0] bcd_next(input logic [4*DIGITS-1:0] v);
		logic [4*DIGITS-1:0] r;
		logic                all_nines;
		int                  i;
		all_nines = 1'b1;
		for (i = 0; i < DIGITS; i++)
			if (v[4*i +: 4] != 4'd9)
				all_nines = 1'b0;
		if (all_nines)
			return v;
		r = v;
		for (i = 0; i < DIGITS; i++) begin
			if (r[4*i +: 4] >= 4'd9) begin
				r[4*i +: 4] = 4'd0;
			end else begin
				r[4*i +: 4] = r[4*i +: 4] + 4'd1;
				break;
			end
		end
		return r;
	endfunction

	task automatic log_failure(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	task automatic format_text_byte(input logic [7:0] c, input logic new_file);
		logic [7:0] chars[$];
		logic       blank;
		logic       number;
		logic       lead;
		logic [3:0] d;
		out_char_t  oc;
		int         i;
		if (new_file) begin
			at_line_start = 1'b1;
			blank_run     = 2'd0;
			line_bcd      = (4*DIGITS)'(1);
		end
		if (at_line_start) begin
			blank = (c == CH_NL);
			if (settings.squeeze_en && blank) begin
				if (blank_run < 2'd2)
					blank_run = blank_run + 2'd1;
				// drop repeated blank line, stay at line start
				if (blank_run > 2'd1)
					return;
			end else begin
				blank_run = blank ? 2'd1 : 2'd0;
			end
			number = (settings.number_mode == NUM_ALL) ||
				(settings.number_mode == NUM_NONBLANK && !blank);
			if (number) begin
				lead = 1'b1;
				for (i = DIGITS - 1; i >= 0; i--) begin
					d = line_bcd[4*i +: 4];
					if (d != 4'd0 || i == 0)
						lead = 1'b0;
					chars.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, d});
				end
				chars.push_back(CH_TAB);
				line_bcd = bcd_next(line_bcd);
			end
			at_line_start = 1'b0;
		end
		if (c == CH_NL)
			at_line_start = 1'b1;
		if (settings.mark_eol && c == CH_NL) begin
			chars.push_back(CH_DOLLAR);
			chars.push_back(c);
		end else if (settings.mark_tab && c == CH_TAB) begin
			chars.push_back(CH_CARET);
			chars.push_back(CH_I);
		end else if (settings.ctrl_visible && c < CTRL_LIMIT && c != CH_NL && c != CH_TAB) begin
			chars.push_back(CH_CARET);
			chars.push_back(c + CARET_OFFSET);
		end else if (settings.ctrl_visible && c >= HIGH_BASE && c <= HIGH_CTRL_TOP) begin
			chars.push_back(CH_M);
			chars.push_back(CH_DASH);
			chars.push_back(CH_CARET);
			chars.push_back(c - CARET_OFFSET);
		end else if (settings.ctrl_visible && c >= META_BASE) begin
			chars.push_back(CH_M);
			chars.push_back(CH_DASH);
			chars.push_back(c - HIGH_BASE);
		end else begin
			chars.push_back(c);
		end
		for (i = 0; i < chars.size(); i++) begin
			oc.ch   = chars[i];
			oc.last = (i == chars.size() - 1);
			pending_chars.push_back(oc);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_char_t exp;
		if (!arst_n) begin
			pending_chars.delete();
			settings      = '0;
			at_line_start = 1'b1;
			blank_run     = 2'd0;
			line_bcd      = (4*DIGITS)'(1);
		end else begin
			// check before predicting: a request taken at this edge cannot show yet
			if (pop && !empty) begin
				chk_count++;
				if (pending_chars.size() == 0) begin
					log_failure($sformatf("expected no output, actual char %02h last %b",
						out_byte, last_of_run));
				end else begin
					exp = pending_chars.pop_front();
					if (out_byte !== exp.ch)
						log_failure($sformatf("out_byte expected %02h actual %02h",
							exp.ch, out_byte));
					if (last_of_run !== exp.last)
						log_failure($sformatf("last_of_run expected %b actual %b (char %02h)",
							exp.last, last_of_run, exp.ch));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NUMBER_MODE:  settings.number_mode  = cfg_data;
					REG_SQUEEZE_EN:   settings.squeeze_en   = cfg_data[0];
					REG_MARK_EOL:     settings.mark_eol     = cfg_data[0];
					REG_MARK_TAB:     settings.mark_tab     = cfg_data[0];
					REG_CTRL_VISIBLE: settings.ctrl_visible = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				take_count++;
				format_text_byte(text_byte, first_of_file);
			end
		end
		mismatches    <= err_count;
		outstanding   <= pending_chars.size();
		chars_checked <= chk_count;
		bytes_taken   <= take_count;
	end

endmodule

// File: tb/tb_text_stream_line_formatter.sv
`timescale 1ns / 1ps
module tb_text_stream_line_formatter import tslf_pkg::*;;

	localparam logic [1:0] NUM_NONE   = 2'd0;
	localparam logic [1:0] NUM_UNUSED = 2'd3;
	localparam int         OPEN_LEN   = 22;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       push          = 1'b0;
	logic [7:0] text_byte     = 8'd0;
	logic       first_of_file = 1'b0;
	logic       pop           = 1'b0;
	logic       cfg_valid     = 1'b0;
	logic [2:0] cfg_index     = 3'd0;
	logic [1:0] cfg_data      = 2'd0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       cfg_ready;

	int         mismatches;
	int         outstanding;
	int         chars_checked;
	int         bytes_taken;
	int         settings_applied = 0;
	bit         idle_on          = 1'b0;
	bit         stall_on         = 1'b0;
	int         pop_hold         = 0;

	logic [8:0] opening_seq [OPEN_LEN] = '{
		{1'b1, 8'h41}, {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_NL}, {1'b0, CH_NL},
		{1'b0, CH_TAB}, {1'b0, 8'h00}, {1'b0, 8'h1F}, {1'b0, 8'h7F}, {1'b0, 8'h80},
		{1'b0, 8'h9F}, {1'b0, 8'hA0}, {1'b0, 8'hFF}, {1'b0, CH_SPACE}, {1'b0, 8'h7E},
		{1'b0, CH_NL}, {1'b0, 8'h78}, {1'b1, CH_NL}, {1'b0, CH_NL}, {1'b0, 8'h79},
		{1'b0, CH_TAB}, {1'b0, CH_NL}
	};

	text_stream_line_formatter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.first_of_file (first_of_file),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tslf_output_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.first_of_file (first_of_file),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.chars_checked (chars_checked),
		.bytes_taken   (bytes_taken)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop      <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (stall_on && $urandom_range(0, 7) == 0) begin
			pop      <= 1'b0;
			pop_hold <= $urandom_range(0, 2);
		end else begin
			pop <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic wait_drained();
		do @(posedge clk); while (outstanding != 0);
		// squeezed lines leave no output; let the pipeline settle
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input cfg_t s);
		wait_drained();
		write_reg(REG_NUMBER_MODE, s.number_mode);
		write_reg(REG_SQUEEZE_EN, {1'($urandom_range(0, 1)), s.squeeze_en});
		write_reg(REG_MARK_EOL, {1'($urandom_range(0, 1)), s.mark_eol});
		write_reg(REG_MARK_TAB, {1'($urandom_range(0, 1)), s.mark_tab});
		write_reg(REG_CTRL_VISIBLE, {1'($urandom_range(0, 1)), s.ctrl_visible});
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic send_char(input logic [7:0] b, input logic new_file);
		push          <= 1'b1;
		text_byte     <= b;
		first_of_file <= new_file;
		do @(posedge clk); while (full);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_text_byte();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return CH_NL;
		if (pick < 22)
			return CH_TAB;
		if (pick < 32)
			return 8'($urandom_range(0, 255));
		if (pick < 36)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic run_random(input cfg_t s, input int count, input bit gaps);
		int n;
		apply_settings(s);
		idle_on  = gaps;
		stall_on = gaps;
		for (n = 0; n < count; n++)
			send_char(random_text_byte(), $urandom_range(0, 29) == 0);
		push <= 1'b0;
	endtask

	initial begin
		cfg_t s;
		int   n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		s = '{NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1};
		apply_settings(s);
		idle_on  = 1'b1;
		stall_on = 1'b1;
		for (n = 0; n < OPEN_LEN; n++)
			send_char(opening_seq[n][7:0], opening_seq[n][8]);
		push <= 1'b0;

		run_random('{NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0}, 35, 1'b1);
		run_random('{NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1}, 35, 1'b1);
		run_random('{NUM_UNUSED, 1'b1, 1'b0, 1'b1, 1'b0}, 35, 1'b0);

		// long file: carry line numbers into a third digit
		apply_settings('{NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0});
		idle_on  = 1'b1;
		stall_on = 1'b1;
		send_char(CH_NL, 1'b1);
		for (n = 0; n < 120; n++)
			send_char((n % 10 == 9) ? 8'h61 : CH_NL, 1'b0);
		push <= 1'b0;

		for (n = 0; n < 3; n++) begin
			s.number_mode  = 2'($urandom_range(0, 3));
			s.squeeze_en   = 1'($urandom_range(0, 1));
			s.mark_eol     = 1'($urandom_range(0, 1));
			s.mark_tab     = 1'($urandom_range(0, 1));
			s.ctrl_visible = 1'($urandom_range(0, 1));
			run_random(s, 35, n != 2);
		end

		wait_drained();
		$display("Run took %0d text bytes under %0d register settings", bytes_taken,
			settings_applied);
		$display("and checked %0d formatted characters.", chars_checked);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: text_stream_line_formatter.f
+incdir+hdl
hdl/tslf_pkg.sv
hdl/tslf_front.sv
hdl/tslf_cmd_fifo.sv
hdl/tslf_back.sv
hdl/text_stream_line_formatter.sv
hdl/tslf_checker.sv
tb/tslf_output_checker.sv
tb/tb_text_stream_line_formatter.sv
